### sv/ctc_pkg.sv
package ctc_pkg;

   // Longest token the suffix count is meant to track; the count saturates.
   localparam int MAX_TOKEN_BYTES = 255;
   localparam int SUFFIX_CAP_INT  = (MAX_TOKEN_BYTES < 255) ? MAX_TOKEN_BYTES : 255;
   localparam logic [7:0] SUFFIX_CAP = 8'(SUFFIX_CAP_INT);

   // Token kind codes
   localparam logic [1:0] KIND_NONE   = 2'd0;
   localparam logic [1:0] KIND_CHORD  = 2'd1;
   localparam logic [1:0] KIND_REPEAT = 2'd2;

   typedef struct packed {
      logic [1:0] token_kind;
      logic [3:0] root_pitch;
      logic [2:0] root_bytes;
      logic [7:0] suffix_bytes;
   } result_type;

endpackage

### sv/ctc_scanner.sv
module ctc_scanner (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         token_byte,
   input  logic               final_byte,
   output ctc_pkg::result_type result
);
   import ctc_pkg::*;

   localparam logic [5:0] ST_R0    = 6'd0;
   localparam logic [5:0] ST_RD    = 6'd1;
   localparam logic [5:0] ST_RF    = 6'd2;
   localparam logic [5:0] ST_RR    = 6'd3;
   localparam logic [5:0] ST_RM    = 6'd4;
   localparam logic [5:0] ST_RL    = 6'd5;
   localparam logic [5:0] ST_RS    = 6'd6;
   localparam logic [5:0] ST_RSO   = 6'd7;
   localparam logic [5:0] ST_RACC  = 6'd8;
   localparam logic [5:0] ST_N     = 6'd9;
   localparam logic [5:0] ST_ALT   = 6'd10;
   localparam logic [5:0] ST_C2    = 6'd11;
   localparam logic [5:0] ST_WM    = 6'd12;
   localparam logic [5:0] ST_WMA   = 6'd13;
   localparam logic [5:0] ST_WMI   = 6'd14;
   localparam logic [5:0] ST_WD    = 6'd15;
   localparam logic [5:0] ST_WDI   = 6'd16;
   localparam logic [5:0] ST_WA    = 6'd17;
   localparam logic [5:0] ST_WAD   = 6'd18;
   localparam logic [5:0] ST_WAU   = 6'd19;
   localparam logic [5:0] ST_WS    = 6'd20;
   localparam logic [5:0] ST_WSU   = 6'd21;
   localparam logic [5:0] ST_WO    = 6'd22;
   localparam logic [5:0] ST_WOM   = 6'd23;
   localparam logic [5:0] ST_WOMI  = 6'd24;
   localparam logic [5:0] ST_WN    = 6'd25;
   localparam logic [5:0] ST_SLASH = 6'd26;
   localparam logic [5:0] ST_BD    = 6'd27;
   localparam logic [5:0] ST_BF    = 6'd28;
   localparam logic [5:0] ST_BR    = 6'd29;
   localparam logic [5:0] ST_BM    = 6'd30;
   localparam logic [5:0] ST_BL    = 6'd31;
   localparam logic [5:0] ST_BS    = 6'd32;
   localparam logic [5:0] ST_BSO   = 6'd33;
   localparam logic [5:0] ST_BACC  = 6'd34;
   localparam logic [5:0] ST_BEND  = 6'd35;
   localparam logic [5:0] ST_P     = 6'd36;
   localparam logic [5:0] ST_PC2   = 6'd37;

   localparam logic [4:0] PW_IDLE = 5'd0;
   localparam logic [4:0] PW_DEAD = 5'd21;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   endfunction

   function automatic logic is_acc(input logic [7:0] c);
      return (c == "#") || (c == "b");
   endfunction

   // Letter-run recognizer for words inside a parenthesized group.
   function automatic logic [4:0] pw_next(input logic [4:0] st, input logic [7:0] c);
      logic [4:0] nx;
      nx = PW_DEAD;
      unique case (st)
         5'd0: begin
            if (c == "n") nx = 5'd1;
            else if (c == "a") nx = 5'd3;
            else if (c == "s") nx = 5'd8;
            else if (c == "m") nx = 5'd11;
            else if (c == "d") nx = 5'd14;
            else if (c == "o") nx = 5'd17;
         end
         5'd1:  if (c == "o") nx = 5'd2;
         5'd3: begin
            if (c == "d") nx = 5'd4;
            else if (c == "u") nx = 5'd6;
         end
         5'd4:  if (c == "d") nx = 5'd5;
         5'd6:  if (c == "g") nx = 5'd7;
         5'd8:  if (c == "u") nx = 5'd9;
         5'd9:  if (c == "s") nx = 5'd10;
         5'd11: if (c == "a") nx = 5'd12;
         5'd12: if (c == "j") nx = 5'd13;
         5'd14: if (c == "i") nx = 5'd15;
         5'd15: if (c == "m") nx = 5'd16;
         5'd17: if (c == "m") nx = 5'd18;
         5'd18: if (c == "i") nx = 5'd19;
         5'd19: if (c == "t") nx = 5'd20;
         default: nx = PW_DEAD;
      endcase
      return nx;
   endfunction

   function automatic logic pw_accept(input logic [4:0] st);
      return (st == 5'd2) || (st == 5'd5) || (st == 5'd7) || (st == 5'd10) ||
             (st == 5'd13) || (st == 5'd16) || (st == 5'd20);
   endfunction

   function automatic logic accept_state(input logic [5:0] st);
      return (st == ST_N) || (st == ST_WM) || (st == ST_BD) || (st == ST_BF) ||
             (st == ST_BACC) || (st == ST_BEND) || (st == ST_RD) || (st == ST_RF) ||
             (st == ST_RACC);
   endfunction

   logic [5:0] scan_state_ff, scan_state_in;
   logic [3:0] pitch_ff, pitch_in;
   logic [2:0] root_len_ff, root_len_in;
   logic [7:0] count_ff, count_in;
   logic       all_special_ff, all_special_in;
   logic       has_special_ff, has_special_in;
   logic       reject_ff, reject_in;
   logic [4:0] pw_ff, pw_in;

   logic [5:0] eff_state;
   logic       root_byte;
   logic [5:0] st_n;
   logic [3:0] pitch_n;
   logic [2:0] rlen_n;
   logic [4:0] pw_n;
   logic       rej_n;
   logic       all_n, has_n;
   logic [7:0] count_n;
   logic [1:0] kind_n;

   // Resolve the lookahead states first: a byte that does not extend them
   // is handled by the state they fall through to.
   always_comb begin
      eff_state = scan_state_ff;
      if (eff_state == ST_RD && token_byte != "o") eff_state = ST_RACC;
      if (eff_state == ST_RF && token_byte != "a") eff_state = ST_RACC;
      if (eff_state == ST_RACC && !is_acc(token_byte)) eff_state = ST_N;
      if (eff_state == ST_WM && token_byte != "a" && token_byte != "i") eff_state = ST_N;
      if (eff_state == ST_WMA && token_byte != "j") eff_state = ST_WA;
   end

   always_comb begin
      st_n      = eff_state;
      pitch_n   = pitch_ff;
      rlen_n    = root_len_ff;
      pw_n      = pw_ff;
      rej_n     = reject_ff;
      root_byte = 1'b0;
      if (!reject_ff) begin
         unique case (eff_state)
            ST_R0: begin
               root_byte = 1'b1;
               unique case (token_byte)
                  "A": begin pitch_n = 4'd9;  rlen_n = 3'd1; st_n = ST_RACC; end
                  "B": begin pitch_n = 4'd11; rlen_n = 3'd1; st_n = ST_RACC; end
                  "C": begin pitch_n = 4'd0;  rlen_n = 3'd1; st_n = ST_RACC; end
                  "E": begin pitch_n = 4'd4;  rlen_n = 3'd1; st_n = ST_RACC; end
                  "G": begin pitch_n = 4'd7;  rlen_n = 3'd1; st_n = ST_RACC; end
                  "D": begin pitch_n = 4'd2;  rlen_n = 3'd1; st_n = ST_RD; end
                  "F": begin pitch_n = 4'd5;  rlen_n = 3'd1; st_n = ST_RF; end
                  "R": st_n = ST_RR;
                  "M": st_n = ST_RM;
                  "L": st_n = ST_RL;
                  "S": st_n = ST_RS;
                  default: rej_n = 1'b1;
               endcase
            end
            ST_RD: begin
               root_byte = 1'b1;
               pitch_n = 4'd0; rlen_n = 3'd2; st_n = ST_RACC;
            end
            ST_RF: begin
               root_byte = 1'b1;
               pitch_n = 4'd5; rlen_n = 3'd2; st_n = ST_RACC;
            end
            ST_RR: begin
               root_byte = 1'b1;
               if (token_byte == "e") begin pitch_n = 4'd2; rlen_n = 3'd2; st_n = ST_RACC; end
               else rej_n = 1'b1;
            end
            ST_RM: begin
               root_byte = 1'b1;
               if (token_byte == "i") begin pitch_n = 4'd4; rlen_n = 3'd2; st_n = ST_RACC; end
               else rej_n = 1'b1;
            end
            ST_RL: begin
               root_byte = 1'b1;
               if (token_byte == "a") begin pitch_n = 4'd9; rlen_n = 3'd2; st_n = ST_RACC; end
               else rej_n = 1'b1;
            end
            ST_RS: begin
               root_byte = 1'b1;
               if (token_byte == "o") st_n = ST_RSO;
               else if (token_byte == "i") begin
                  pitch_n = 4'd11; rlen_n = 3'd2; st_n = ST_RACC;
               end
               else rej_n = 1'b1;
            end
            ST_RSO: begin
               root_byte = 1'b1;
               if (token_byte == "l") begin pitch_n = 4'd7; rlen_n = 3'd3; st_n = ST_RACC; end
               else rej_n = 1'b1;
            end
            ST_RACC: begin
               // only sharp or flat reach here
               root_byte = 1'b1;
               if (token_byte == "#") pitch_n = (pitch_ff == 4'd11) ? 4'd0 : pitch_ff + 4'd1;
               else pitch_n = (pitch_ff == 4'd0) ? 4'd11 : pitch_ff - 4'd1;
               rlen_n = root_len_ff + 3'd1;
               st_n   = ST_N;
            end
            ST_N: begin
               if (is_digit(token_byte) || token_byte == "+" || token_byte == "-" ||
                   token_byte == "M" || token_byte == "h") st_n = ST_N;
               else if (token_byte == "/") st_n = ST_SLASH;
               else if (token_byte == "(") begin st_n = ST_P; pw_n = PW_IDLE; end
               else if (is_acc(token_byte)) st_n = ST_ALT;
               else if (token_byte == 8'hC2) st_n = ST_C2;
               else if (token_byte == "m") st_n = ST_WM;
               else if (token_byte == "d") st_n = ST_WD;
               else if (token_byte == "a") st_n = ST_WA;
               else if (token_byte == "s") st_n = ST_WS;
               else if (token_byte == "o") st_n = ST_WO;
               else if (token_byte == "n") st_n = ST_WN;
               else rej_n = 1'b1;
            end
            ST_ALT: if (is_digit(token_byte)) st_n = ST_N; else rej_n = 1'b1;
            ST_C2:  if (token_byte == 8'hBA) st_n = ST_N; else rej_n = 1'b1;
            ST_WM:  st_n = (token_byte == "a") ? ST_WMA : ST_WMI;
            ST_WMA: st_n = ST_N;
            ST_WMI: if (token_byte == "n") st_n = ST_N; else rej_n = 1'b1;
            ST_WD:  if (token_byte == "i") st_n = ST_WDI; else rej_n = 1'b1;
            ST_WDI: if (token_byte == "m") st_n = ST_N; else rej_n = 1'b1;
            ST_WA: begin
               if (token_byte == "d") st_n = ST_WAD;
               else if (token_byte == "u") st_n = ST_WAU;
               else rej_n = 1'b1;
            end
            ST_WAD:  if (token_byte == "d") st_n = ST_N; else rej_n = 1'b1;
            ST_WAU:  if (token_byte == "g") st_n = ST_N; else rej_n = 1'b1;
            ST_WS:   if (token_byte == "u") st_n = ST_WSU; else rej_n = 1'b1;
            ST_WSU:  if (token_byte == "s") st_n = ST_N; else rej_n = 1'b1;
            ST_WO:   if (token_byte == "m") st_n = ST_WOM; else rej_n = 1'b1;
            ST_WOM:  if (token_byte == "i") st_n = ST_WOMI; else rej_n = 1'b1;
            ST_WOMI: if (token_byte == "t") st_n = ST_N; else rej_n = 1'b1;
            ST_WN:   if (token_byte == "o") st_n = ST_N; else rej_n = 1'b1;
            ST_SLASH: begin
               unique case (token_byte)
                  "A", "B", "C", "E", "G": st_n = ST_BACC;
                  "D": st_n = ST_BD;
                  "F": st_n = ST_BF;
                  "R": st_n = ST_BR;
                  "M": st_n = ST_BM;
                  "L": st_n = ST_BL;
                  "S": st_n = ST_BS;
                  default: begin
                     if (is_digit(token_byte)) st_n = ST_N;
                     else rej_n = 1'b1;
                  end
               endcase
            end
            ST_BD, ST_BF: begin
               if (token_byte == ((eff_state == ST_BD) ? 8'("o") : 8'("a"))) st_n = ST_BACC;
               else if (is_acc(token_byte)) st_n = ST_BEND;
               else rej_n = 1'b1;
            end
            ST_BR:  if (token_byte == "e") st_n = ST_BACC; else rej_n = 1'b1;
            ST_BM:  if (token_byte == "i") st_n = ST_BACC; else rej_n = 1'b1;
            ST_BL:  if (token_byte == "a") st_n = ST_BACC; else rej_n = 1'b1;
            ST_BS: begin
               if (token_byte == "o") st_n = ST_BSO;
               else if (token_byte == "i") st_n = ST_BACC;
               else rej_n = 1'b1;
            end
            ST_BSO:  if (token_byte == "l") st_n = ST_BACC; else rej_n = 1'b1;
            ST_BACC: if (is_acc(token_byte)) st_n = ST_BEND; else rej_n = 1'b1;
            ST_P: begin
               if (pw_ff != PW_IDLE && is_letter(token_byte)) begin
                  pw_n = pw_next(pw_ff, token_byte);
               end else if (pw_ff != PW_IDLE && !pw_accept(pw_ff)) begin
                  rej_n = 1'b1;
               end else begin
                  // word closed (or none open): take the byte as a group item
                  pw_n = PW_IDLE;
                  if (is_digit(token_byte) || is_acc(token_byte)) st_n = ST_P;
                  else if (token_byte == ")") st_n = ST_N;
                  else if (token_byte == 8'hC2) st_n = ST_PC2;
                  else if (is_letter(token_byte)) pw_n = pw_next(PW_IDLE, token_byte);
                  else rej_n = 1'b1;
               end
            end
            ST_PC2: if (token_byte == 8'hBA) st_n = ST_P; else rej_n = 1'b1;
            default: rej_n = 1'b1;
         endcase
      end else begin
         st_n = scan_state_ff;
      end
   end

   // Repeat-marker flags, the saturating suffix count, and the token kind and result fields
   always_comb begin
      all_n = all_special_ff;
      has_n = has_special_ff;
      if (token_byte == "|" || token_byte == ":" || token_byte == "-") has_n = 1'b1;
      else if (!is_digit(token_byte)) all_n = 1'b0;

      count_n = count_ff;
      if (!reject_ff && !root_byte && count_ff < SUFFIX_CAP) count_n = count_ff + 8'd1;

      if (all_n && has_n) kind_n = KIND_REPEAT;
      else if (!rej_n && accept_state(st_n)) kind_n = KIND_CHORD;
      else kind_n = KIND_NONE;

      result.token_kind   = kind_n;
      result.root_pitch   = (kind_n == KIND_CHORD) ? pitch_n : 4'd0;
      result.root_bytes   = (kind_n == KIND_CHORD) ? rlen_n : 3'd0;
      result.suffix_bytes = (kind_n == KIND_CHORD) ? count_n : 8'd0;
   end

   // Commit on each step; drop back to the start state after the last byte.
   always_comb begin
      scan_state_in  = scan_state_ff;
      pitch_in       = pitch_ff;
      root_len_in    = root_len_ff;
      count_in       = count_ff;
      all_special_in = all_special_ff;
      has_special_in = has_special_ff;
      reject_in      = reject_ff;
      pw_in          = pw_ff;
      if (step) begin
         if (final_byte) begin
            scan_state_in  = ST_R0;
            pitch_in       = 4'd0;
            root_len_in    = 3'd0;
            count_in       = 8'd0;
            all_special_in = 1'b1;
            has_special_in = 1'b0;
            reject_in      = 1'b0;
            pw_in          = PW_IDLE;
         end else begin
            scan_state_in  = st_n;
            pitch_in       = pitch_n;
            root_len_in    = rlen_n;
            count_in       = count_n;
            all_special_in = all_n;
            has_special_in = has_n;
            reject_in      = rej_n;
            pw_in          = pw_n;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_state_ff  <= ST_R0;
         pitch_ff       <= 4'd0;
         root_len_ff    <= 3'd0;
         count_ff       <= 8'd0;
         all_special_ff <= 1'b1;
         has_special_ff <= 1'b0;
         reject_ff      <= 1'b0;
         pw_ff          <= PW_IDLE;
      end else begin
         scan_state_ff  <= scan_state_in;
         pitch_ff       <= pitch_in;
         root_len_ff    <= root_len_in;
         count_ff       <= count_in;
         all_special_ff <= all_special_in;
         has_special_ff <= has_special_in;
         reject_ff      <= reject_in;
         pw_ff          <= pw_in;
      end
   end

endmodule

### sv/ctc_rsp_reg.sv
module ctc_rsp_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  ctc_pkg::result_type load_data,
   input  logic                rsp_ready,
   output logic                free,
   output logic                rsp_valid,
   output ctc_pkg::result_type rsp_data
);
   import ctc_pkg::*;

   logic       valid_ff, valid_in;
   result_type data_ff, data_in;

   // The register can take a new result when empty or being drained.
   assign free = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

### sv/chord_token_classifier.sv
// A final byte is held in the input register and scanned once the result register is
// free; the result register then loads its result and raises rsp_valid.
// Throughput: one byte per cycle unless a final byte is stalled; the byte scanner
// updates its state in a single pass. Backpressure stalls only a final byte whose result
// register is still occupied. Reset (synchronous, active high) empties both registers
// and returns the scanner to the start of a token.
module chord_token_classifier (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_token_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [1:0] rsp_token_kind,
   output logic [3:0] rsp_root_pitch,
   output logic [2:0] rsp_root_bytes,
   output logic [7:0] rsp_suffix_bytes
);
   import ctc_pkg::*;

   // Input register: holds one request byte in front of the scanner.
   logic       in_vld_ff, in_vld_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       in_final_ff, in_final_in;

   logic       proc_fire;
   logic       rsp_free;
   result_type scan_result;
   result_type rsp_data;

   // Advance the held byte into the scanner. Non-final bytes never wait;
   // a final byte waits until the result register can take its result.
   assign proc_fire = in_vld_ff && (!in_final_ff || rsp_free);

   // Accept a new request whenever the input register is empty or empties this cycle.
   assign req_ready = !in_vld_ff || proc_fire;

   always_comb begin
      in_vld_in   = in_vld_ff;
      in_byte_in  = in_byte_ff;
      in_final_in = in_final_ff;
      if (req_valid && req_ready) begin
         in_vld_in   = 1'b1;
         in_byte_in  = req_token_byte;
         in_final_in = req_final_byte;
      end else if (proc_fire) begin
         in_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_vld_ff <= 1'b0;
      else       in_vld_ff <= in_vld_in;
   end

   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      in_final_ff <= in_final_in;
   end

   // Token scanner: state machine with one-byte lookahead, plus the
   // repeat-marker flags and the saturating suffix counter.
   ctc_scanner u_scanner (
      .clock      (clock),
      .reset      (reset),
      .step       (proc_fire),
      .token_byte (in_byte_ff),
      .final_byte (in_final_ff),
      .result     (scan_result)
   );

   // Result register: load on the final byte of each token.
   ctc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (proc_fire && in_final_ff),
      .load_data (scan_result),
      .rsp_ready (rsp_ready),
      .free      (rsp_free),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_token_kind   = rsp_data.token_kind;
   assign rsp_root_pitch   = rsp_data.root_pitch;
   assign rsp_root_bytes   = rsp_data.root_bytes;
   assign rsp_suffix_bytes = rsp_data.suffix_bytes;

endmodule

### sv/ctc_checker.sv
module ctc_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic [7:0] req_token_byte,
   input logic       req_final_byte,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [1:0] rsp_token_kind,
   input logic [3:0] rsp_root_pitch,
   input logic [2:0] rsp_root_bytes,
   input logic [7:0] rsp_suffix_bytes
);
   import ctc_pkg::*;

   // Hold a stalled response steady.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_token_kind) &&
      $stable(rsp_root_pitch) && $stable(rsp_root_bytes) && $stable(rsp_suffix_bytes))
      else $error("response changed while stalled");

   // Non-chord results carry zero fields.
   a_nonchord_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind != KIND_CHORD |->
      rsp_root_pitch == 4'd0 && rsp_root_bytes == 3'd0 && rsp_suffix_bytes == 8'd0)
      else $error("non-chord result with nonzero fields");

   // Chord results have a legal pitch and root length.
   a_chord_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_token_kind == KIND_CHORD |->
      rsp_root_pitch <= 4'd11 && rsp_root_bytes >= 3'd1 && rsp_root_bytes <= 3'd4)
      else $error("chord result out of range");

   // Drop any response on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind chord_token_classifier ctc_checker u_ctc_checker (.*);
